[src/ptzcf_pkg.sv]
package ptzcf_pkg;

  // Command kinds carried on the mode field.
  typedef enum logic [1:0] {
    MODE_AIM_POS  = 2'd0,
    MODE_AIM_SPD  = 2'd1,
    MODE_ZOOM_POS = 2'd2,
    MODE_ZOOM_SPD = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CAMERA_ADDRESS      = 3'd0,
    CFG_PAN_POSITION_LIMIT  = 3'd1,
    CFG_TILT_POSITION_LIMIT = 3'd2,
    CFG_PAN_RATE_LIMIT      = 3'd3,
    CFG_TILT_RATE_LIMIT     = 3'd4,
    CFG_ZOOM_POSITION_LIMIT = 3'd5,
    CFG_ZOOM_RATE_FLOOR     = 3'd6,
    CFG_ZOOM_RATE_CEILING   = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [2:0]  camera_address;
    logic [14:0] pan_position_limit;
    logic [14:0] tilt_position_limit;
    logic [7:0]  pan_rate_limit;
    logic [7:0]  tilt_rate_limit;
    logic [15:0] zoom_position_limit;
    logic [3:0]  zoom_rate_floor;
    logic [3:0]  zoom_rate_ceiling;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    camera_address:      3'd1,
    pan_position_limit:  15'd880,
    tilt_position_limit: 15'd300,
    pan_rate_limit:      8'd24,
    tilt_rate_limit:     8'd20,
    zoom_position_limit: 16'd1023,
    zoom_rate_floor:     4'd2,
    zoom_rate_ceiling:   4'd7
  };

  // Classified command: everything the back end needs to spell the frame.
  //   aim position: byte_a/b speed limits, code_a/b pan/tilt position codes
  //   aim speed:    byte_a/b speeds, dir_a/b direction codes
  //   zoom position: code_a zoom target
  //   zoom speed:    byte_a zoom code
  typedef struct packed {
    mode_e       mode;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [15:0] code_a;
    logic [15:0] code_b;
    logic [1:0]  dir_a;
    logic [1:0]  dir_b;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int unsigned QDepth = 2;

  // Direction codes of the speed drive command.
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;
  localparam logic [1:0] DIR_STOP = 2'd3;

  // Frame bytes.
  localparam logic [7:0] HDR_BASE       = 8'h80;
  localparam logic [7:0] MSG_COMMAND    = 8'h01;
  localparam logic [7:0] CAT_PANTILT    = 8'h06;
  localparam logic [7:0] CAT_LENS       = 8'h04;
  localparam logic [7:0] OP_ABS_POS     = 8'h02;
  localparam logic [7:0] OP_DRIVE       = 8'h01;
  localparam logic [7:0] OP_ZOOM_DIRECT = 8'h47;
  localparam logic [7:0] OP_ZOOM_DRIVE  = 8'h07;
  localparam logic [7:0] FRAME_END      = 8'hFF;
  localparam logic [3:0] ZOOM_TELE      = 4'h2;
  localparam logic [3:0] ZOOM_WIDE      = 4'h3;

  // Frame lengths in bytes.
  localparam int unsigned LenAimPos  = 15;
  localparam int unsigned LenAimSpd  = 9;
  localparam int unsigned LenZoomPos = 9;
  localparam int unsigned LenZoomSpd = 6;

endpackage

[src/ptz_camera_command_framer.sv]
// Camera command framer: turns one motion command into its serial control
// frame, one byte per output beat, with frame_last_o set on the closing 0xFF.
//
// Input channel: in_valid_i / in_stall_o with mode_i and the five signed
// fields. A beat is taken when in_valid_i is high and in_stall_o is low.
// Accepted commands are clamped to the configured limits at once and parked
// in a two-entry command queue, so the input stalls only when that queue is
// full. Output channel: out_valid_o / out_stall_i, one frame byte per beat,
// from an output register.
// The command passes through the queue and then the output register before
// its header byte reaches the output. The serializer walks the frame at one
// byte per cycle while out_stall_i is low; a frame is 15 (aim position),
// 9 (aim speed, zoom position) or 6 (zoom speed) bytes long.
// While out_stall_i is high the output beat holds and the serializer waits;
// the input side keeps filling the queue until it is full.
// Configuration: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i picks
// the register, cfg_data_i carries the value; write only while idle.
// Reset (rst_ni low, asynchronous) empties the queue, drops any beat in
// flight and restores the default register values.
module ptz_camera_command_framer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ptzcf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ptzcf_pkg::CfgDataW-1:0]      cfg_data_i,
  // command input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic signed [15:0]                  pan_position_i,
  input  logic signed [15:0]                  tilt_position_i,
  input  logic signed [15:0]                  pan_speed_i,
  input  logic signed [15:0]                  tilt_speed_i,
  input  logic signed [15:0]                  zoom_value_i,
  // frame output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          frame_byte_o,
  output logic                                frame_last_o
);

  ptzcf_pkg::cfg_t    cfg_q, cfg_d;
  ptzcf_pkg::cmd_t    front_cmd;
  ptzcf_pkg::cmd_t    head_cmd;
  ptzcf_pkg::q_stat_t q_stat;
  logic               push;
  logic               pop;

  // Configuration registers; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (ptzcf_pkg::cfg_idx_e'(cfg_index_i))
        ptzcf_pkg::CFG_CAMERA_ADDRESS:      cfg_d.camera_address      = cfg_data_i[2:0];
        ptzcf_pkg::CFG_PAN_POSITION_LIMIT:  cfg_d.pan_position_limit  = cfg_data_i[14:0];
        ptzcf_pkg::CFG_TILT_POSITION_LIMIT: cfg_d.tilt_position_limit = cfg_data_i[14:0];
        ptzcf_pkg::CFG_PAN_RATE_LIMIT:      cfg_d.pan_rate_limit      = cfg_data_i[7:0];
        ptzcf_pkg::CFG_TILT_RATE_LIMIT:     cfg_d.tilt_rate_limit     = cfg_data_i[7:0];
        ptzcf_pkg::CFG_ZOOM_POSITION_LIMIT: cfg_d.zoom_position_limit = cfg_data_i;
        ptzcf_pkg::CFG_ZOOM_RATE_FLOOR:     cfg_d.zoom_rate_floor     = cfg_data_i[3:0];
        ptzcf_pkg::CFG_ZOOM_RATE_CEILING:   cfg_d.zoom_rate_ceiling   = cfg_data_i[3:0];
        default:                            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ptzcf_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify and clamp the command as it arrives.
  ptzcf_front u_front (
    .cfg_i           (cfg_q),
    .mode_i          (mode_i),
    .pan_position_i  (pan_position_i),
    .tilt_position_i (tilt_position_i),
    .pan_speed_i     (pan_speed_i),
    .tilt_speed_i    (tilt_speed_i),
    .zoom_value_i    (zoom_value_i),
    .cmd_o           (front_cmd)
  );

  // Stall the input only when the command queue has no room.
  assign in_stall_o = q_stat.full;
  assign push       = in_valid_i && !q_stat.full;

  ptzcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .stat_o  (q_stat)
  );

  // Back: walk the frame of the head command, one byte per beat.
  ptzcf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .camera_address_i (cfg_q.camera_address),
    .cmd_i            (head_cmd),
    .cmd_valid_i      (!q_stat.empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_byte_o     (frame_byte_o),
    .frame_last_o     (frame_last_o)
  );

`ifndef SYNTHESIS
  // The serializer only retires a command that the queue holds.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("command retired from an empty queue");

  // Every frame closes on the end byte.
  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> frame_byte_o == ptzcf_pkg::FRAME_END)
    else $error("last beat is not the end byte");

  // A beat following a finished frame opens a new frame with a header.
  a_header_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && frame_last_o |=>
      !out_valid_o || frame_byte_o[7:3] == ptzcf_pkg::HDR_BASE[7:3])
    else $error("frame does not open with a header byte");

  // The input is held off exactly when the queue is full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !push && q_stat.full)
    else $error("input stalled with room in the queue");
`endif

endmodule

[src/ptzcf_front.sv]
module ptzcf_front (
  input  ptzcf_pkg::cfg_t        cfg_i,
  input  logic [1:0]             mode_i,
  input  logic signed [15:0]     pan_position_i,
  input  logic signed [15:0]     tilt_position_i,
  input  logic signed [15:0]     pan_speed_i,
  input  logic signed [15:0]     tilt_speed_i,
  input  logic signed [15:0]     zoom_value_i,
  output ptzcf_pkg::cmd_t        cmd_o
);

  // Clamp a signed position to +/- limit, result as 16-bit two's complement.
  function automatic logic [15:0] pos_code(input logic signed [15:0] pos,
                                           input logic [14:0] limit);
    logic signed [16:0] p;
    logic signed [16:0] lim;
    logic signed [16:0] nlim;
    begin
      p    = {pos[15], pos};
      lim  = {2'b00, limit};
      nlim = -lim;
      if (p > lim) begin
        pos_code = lim[15:0];
      end else if (p < nlim) begin
        pos_code = nlim[15:0];
      end else begin
        pos_code = pos;
      end
    end
  endfunction

  // Negative clamps to zero, positive to the limit.
  function automatic logic [7:0] rate_clamp(input logic signed [15:0] v,
                                            input logic [7:0] limit);
    begin
      if (v[15]) begin
        rate_clamp = 8'd0;
      end else if (v > $signed({8'd0, limit})) begin
        rate_clamp = limit;
      end else begin
        rate_clamp = v[7:0];
      end
    end
  endfunction

  function automatic logic [15:0] magnitude(input logic signed [15:0] v);
    begin
      magnitude = v[15] ? (~v + 16'd1) : v;
    end
  endfunction

  function automatic logic [7:0] mag_clamp(input logic signed [15:0] v,
                                           input logic [7:0] limit);
    logic [15:0] m;
    begin
      m = magnitude(v);
      mag_clamp = (m > {8'd0, limit}) ? limit : m[7:0];
    end
  endfunction

  function automatic logic [1:0] dir_code(input logic signed [15:0] v);
    begin
      if (v == 16'sd0) begin
        dir_code = ptzcf_pkg::DIR_STOP;
      end else if (v[15]) begin
        dir_code = ptzcf_pkg::DIR_NEG;
      end else begin
        dir_code = ptzcf_pkg::DIR_POS;
      end
    end
  endfunction

  logic [15:0]        zoom_pos;
  logic [7:0]         zoom_code;
  logic signed [16:0] zv;
  logic signed [16:0] zfloor;
  logic [15:0]        zmag;

  assign zv     = {zoom_value_i[15], zoom_value_i};
  assign zfloor = {13'd0, cfg_i.zoom_rate_floor};
  assign zmag   = magnitude(zoom_value_i);

  always_comb begin
    if (zoom_value_i[15] || zoom_value_i == 16'sd0) begin
      zoom_pos = 16'd0;
    end else if (zoom_value_i > cfg_i.zoom_position_limit) begin
      zoom_pos = cfg_i.zoom_position_limit;
    end else begin
      zoom_pos = zoom_value_i;
    end
  end

  always_comb begin
    if (zv >= zfloor) begin
      zoom_code = {ptzcf_pkg::ZOOM_TELE,
                   (zmag > {12'd0, cfg_i.zoom_rate_ceiling}) ?
                   cfg_i.zoom_rate_ceiling : zmag[3:0]};
    end else if (zv <= -zfloor) begin
      zoom_code = {ptzcf_pkg::ZOOM_WIDE,
                   (zmag > {12'd0, cfg_i.zoom_rate_ceiling}) ?
                   cfg_i.zoom_rate_ceiling : zmag[3:0]};
    end else begin
      zoom_code = 8'd0;
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.mode   = ptzcf_pkg::mode_e'(mode_i);
    case (ptzcf_pkg::mode_e'(mode_i))
      ptzcf_pkg::MODE_AIM_POS: begin
        cmd_o.byte_a = rate_clamp(pan_speed_i, cfg_i.pan_rate_limit);
        cmd_o.byte_b = rate_clamp(tilt_speed_i, cfg_i.tilt_rate_limit);
        cmd_o.code_a = pos_code(pan_position_i, cfg_i.pan_position_limit);
        cmd_o.code_b = pos_code(tilt_position_i, cfg_i.tilt_position_limit);
      end
      ptzcf_pkg::MODE_AIM_SPD: begin
        cmd_o.byte_a = mag_clamp(pan_speed_i, cfg_i.pan_rate_limit);
        cmd_o.byte_b = mag_clamp(tilt_speed_i, cfg_i.tilt_rate_limit);
        cmd_o.dir_a  = dir_code(pan_speed_i);
        cmd_o.dir_b  = dir_code(tilt_speed_i);
      end
      ptzcf_pkg::MODE_ZOOM_POS: begin
        cmd_o.code_a = zoom_pos;
      end
      ptzcf_pkg::MODE_ZOOM_SPD: begin
        cmd_o.byte_a = zoom_code;
      end
      default: begin
        cmd_o.byte_a = zoom_code;
      end
    endcase
  end

endmodule

[src/ptzcf_queue.sv]
module ptzcf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ptzcf_pkg::cmd_t     wdata_i,
  input  logic                pop_i,
  output ptzcf_pkg::cmd_t     rdata_o,
  output ptzcf_pkg::q_stat_t  stat_o
);

  localparam int unsigned PtrW = (ptzcf_pkg::QDepth > 1) ? $clog2(ptzcf_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(ptzcf_pkg::QDepth + 1);

  ptzcf_pkg::cmd_t entry_q [ptzcf_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    begin
      ptr_inc = (p == PtrW'(ptzcf_pkg::QDepth - 1)) ? '0 : p + PtrW'(1);
    end
  endfunction

  assign stat_o.full  = (count_q == CntW'(ptzcf_pkg::QDepth));
  assign stat_o.empty = (count_q == '0);
  assign rdata_o      = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[src/ptzcf_back.sv]
module ptzcf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       camera_address_i,
  input  ptzcf_pkg::cmd_t  cmd_i,
  input  logic             cmd_valid_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       frame_byte_o,
  output logic             frame_last_o
);

  logic [3:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       load;
  logic       emit;
  logic [7:0] hdr;
  logic [3:0] last_idx;

  function automatic logic [7:0] nib(input logic [15:0] code, input logic [1:0] k);
    begin
      case (k)
        2'd0:    nib = {4'd0, code[15:12]};
        2'd1:    nib = {4'd0, code[11:8]};
        2'd2:    nib = {4'd0, code[7:4]};
        default: nib = {4'd0, code[3:0]};
      endcase
    end
  endfunction

  assign hdr  = ptzcf_pkg::HDR_BASE | {5'd0, camera_address_i};
  assign load = !out_valid_q || !out_stall_i;
  assign emit = load && cmd_valid_i;

  always_comb begin
    case (cmd_i.mode)
      ptzcf_pkg::MODE_AIM_POS:  last_idx = 4'(ptzcf_pkg::LenAimPos - 1);
      ptzcf_pkg::MODE_AIM_SPD:  last_idx = 4'(ptzcf_pkg::LenAimSpd - 1);
      ptzcf_pkg::MODE_ZOOM_POS: last_idx = 4'(ptzcf_pkg::LenZoomPos - 1);
      default:                  last_idx = 4'(ptzcf_pkg::LenZoomSpd - 1);
    endcase
  end

  // Byte at the current position of the frame.
  always_comb begin
    byte_d = ptzcf_pkg::FRAME_END;
    if (idx_q == 4'd0) begin
      byte_d = hdr;
    end else if (idx_q == 4'd1) begin
      byte_d = ptzcf_pkg::MSG_COMMAND;
    end else begin
      case (cmd_i.mode)
        ptzcf_pkg::MODE_AIM_POS: begin
          case (idx_q)
            4'd2:    byte_d = ptzcf_pkg::CAT_PANTILT;
            4'd3:    byte_d = ptzcf_pkg::OP_ABS_POS;
            4'd4:    byte_d = cmd_i.byte_a;
            4'd5:    byte_d = cmd_i.byte_b;
            4'd6, 4'd7, 4'd8, 4'd9:
                     byte_d = nib(cmd_i.code_a, 2'(idx_q - 4'd6));
            4'd10, 4'd11, 4'd12, 4'd13:
                     byte_d = nib(cmd_i.code_b, 2'(idx_q - 4'd10));
            default: byte_d = ptzcf_pkg::FRAME_END;
          endcase
        end
        ptzcf_pkg::MODE_AIM_SPD: begin
          case (idx_q)
            4'd2:    byte_d = ptzcf_pkg::CAT_PANTILT;
            4'd3:    byte_d = ptzcf_pkg::OP_DRIVE;
            4'd4:    byte_d = cmd_i.byte_a;
            4'd5:    byte_d = cmd_i.byte_b;
            4'd6:    byte_d = {6'd0, cmd_i.dir_a};
            4'd7:    byte_d = {6'd0, cmd_i.dir_b};
            default: byte_d = ptzcf_pkg::FRAME_END;
          endcase
        end
        ptzcf_pkg::MODE_ZOOM_POS: begin
          case (idx_q)
            4'd2:    byte_d = ptzcf_pkg::CAT_LENS;
            4'd3:    byte_d = ptzcf_pkg::OP_ZOOM_DIRECT;
            4'd4, 4'd5, 4'd6, 4'd7:
                     byte_d = nib(cmd_i.code_a, 2'(idx_q - 4'd4));
            default: byte_d = ptzcf_pkg::FRAME_END;
          endcase
        end
        default: begin
          case (idx_q)
            4'd2:    byte_d = ptzcf_pkg::CAT_LENS;
            4'd3:    byte_d = ptzcf_pkg::OP_ZOOM_DRIVE;
            4'd4:    byte_d = cmd_i.byte_a;
            default: byte_d = ptzcf_pkg::FRAME_END;
          endcase
        end
      endcase
    end
  end

  assign last_d = (idx_q == last_idx);
  assign pop_o  = emit && last_d;

  always_comb begin
    idx_d = idx_q;
    if (emit) begin
      idx_d = last_d ? 4'd0 : idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign frame_last_o = last_q;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ptzcf_pkg::*;

  // One motion command as it sits on the input channel.
  typedef struct {
    mode_e              mode;
    logic signed [15:0] pan_pos;
    logic signed [15:0] tilt_pos;
    logic signed [15:0] pan_spd;
    logic signed [15:0] tilt_spd;
    logic signed [15:0] zoom_val;
  } motion_cmd_t;

  // One frame byte as it should leave the output channel.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = '0;
  logic signed [15:0] pan_position_i = '0;
  logic signed [15:0] tilt_position_i = '0;
  logic signed [15:0] pan_speed_i = '0;
  logic signed [15:0] tilt_speed_i = '0;
  logic signed [15:0] zoom_value_i = '0;

  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] frame_byte_o;
  logic       frame_last_o;

  // Shadow copy of the register file, updated on every accepted write.
  cfg_t cfg_model = CFG_RESET;

  // Frame bytes still owed by the block, oldest first.
  frame_beat_t frame_expect_q[$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_checked = 0;
  int unsigned settings_loaded = 0;
  int unsigned mode_count[4] = '{0, 0, 0, 0};

  // Idling switches: when off, that side runs flat out.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  // Long output hold, loaded by the backpressure test and counted down
  // by the receiver process.
  int rx_hold_left = 0;
  int rx_wait;

  ptz_camera_command_framer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .pan_position_i  (pan_position_i),
    .tilt_position_i (tilt_position_i),
    .pan_speed_i     (pan_speed_i),
    .tilt_speed_i    (tilt_speed_i),
    .zoom_value_i    (zoom_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_byte_o    (frame_byte_o),
    .frame_last_o    (frame_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------

  function automatic int min_of(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // Speed limit byte of the absolute move: negative goes to zero, the rest
  // saturates at the rate register.
  function automatic logic [7:0] limit_rate(int v, int limit);
    return (v < 0) ? 8'h00 : 8'(min_of(v, limit));
  endfunction

  // Clamp a signed position to +/- limit; negatives travel as 16-bit
  // two's complement.
  function automatic logic [15:0] position_word(int p, int limit);
    if (p > 0) return 16'(min_of(p, limit));
    if (p < 0) return 16'(-min_of(-p, limit));
    return 16'h0000;
  endfunction

  // Split a signed velocity into its magnitude byte and direction code.
  function automatic void drive_speed(input int v, input int limit,
                                      output logic [7:0] spd,
                                      output logic [7:0] dir);
    spd = 8'h00;
    dir = {6'd0, DIR_STOP};
    if (v > 0) begin
      spd = 8'(min_of(v, limit));
      dir = {6'd0, DIR_POS};
    end else if (v < 0) begin
      spd = 8'(min_of(-v, limit));
      dir = {6'd0, DIR_NEG};
    end
  endfunction

  function automatic void owe_byte(logic [7:0] b, logic last);
    frame_beat_t beat;
    beat.frame_byte = b;
    beat.frame_last = last;
    frame_expect_q.push_back(beat);
  endfunction

  // Four nibbles, high first, one per byte.
  function automatic void owe_nibbles(logic [15:0] w);
    for (int k = 3; k >= 0; k--) owe_byte({4'h0, w[4*k +: 4]}, 1'b0);
  endfunction

  // Queue every byte of the frame that this command must produce.
  function automatic void predict_frame(motion_cmd_t c);
    logic [7:0] pan_b, tilt_b, pan_d, tilt_d;
    int         zv, zlo, zhi;
    zv  = c.zoom_val;
    zlo = cfg_model.zoom_rate_floor;
    zhi = cfg_model.zoom_rate_ceiling;
    owe_byte(HDR_BASE + {5'd0, cfg_model.camera_address}, 1'b0);
    owe_byte(MSG_COMMAND, 1'b0);
    case (c.mode)
      MODE_AIM_POS: begin
        owe_byte(CAT_PANTILT, 1'b0);
        owe_byte(OP_ABS_POS, 1'b0);
        owe_byte(limit_rate(c.pan_spd, cfg_model.pan_rate_limit), 1'b0);
        owe_byte(limit_rate(c.tilt_spd, cfg_model.tilt_rate_limit), 1'b0);
        owe_nibbles(position_word(c.pan_pos, cfg_model.pan_position_limit));
        owe_nibbles(position_word(c.tilt_pos, cfg_model.tilt_position_limit));
      end
      MODE_AIM_SPD: begin
        drive_speed(c.pan_spd, cfg_model.pan_rate_limit, pan_b, pan_d);
        drive_speed(c.tilt_spd, cfg_model.tilt_rate_limit, tilt_b, tilt_d);
        owe_byte(CAT_PANTILT, 1'b0);
        owe_byte(OP_DRIVE, 1'b0);
        owe_byte(pan_b, 1'b0);
        owe_byte(tilt_b, 1'b0);
        owe_byte(pan_d, 1'b0);
        owe_byte(tilt_d, 1'b0);
      end
      MODE_ZOOM_POS: begin
        owe_byte(CAT_LENS, 1'b0);
        owe_byte(OP_ZOOM_DIRECT, 1'b0);
        owe_nibbles((zv > 0) ? 16'(min_of(zv, cfg_model.zoom_position_limit)) : 16'h0000);
      end
      MODE_ZOOM_SPD: begin
        owe_byte(CAT_LENS, 1'b0);
        owe_byte(OP_ZOOM_DRIVE, 1'b0);
        // Dead band between -floor and +floor sends the stop code.
        if (zv >= zlo)
          owe_byte({ZOOM_TELE, 4'(min_of(zv, zhi))}, 1'b0);
        else if (zv <= -zlo)
          owe_byte({ZOOM_WIDE, 4'(min_of(-zv, zhi))}, 1'b0);
        else
          owe_byte(8'h00, 1'b0);
      end
    endcase
    owe_byte(FRAME_END, 1'b1);
  endfunction

  // Keep only the register's own bits of the write data.
  function automatic void store_register(cfg_idx_e idx, logic [15:0] word);
    case (idx)
      CFG_CAMERA_ADDRESS:      cfg_model.camera_address      = word[2:0];
      CFG_PAN_POSITION_LIMIT:  cfg_model.pan_position_limit  = word[14:0];
      CFG_TILT_POSITION_LIMIT: cfg_model.tilt_position_limit = word[14:0];
      CFG_PAN_RATE_LIMIT:      cfg_model.pan_rate_limit      = word[7:0];
      CFG_TILT_RATE_LIMIT:     cfg_model.tilt_rate_limit     = word[7:0];
      CFG_ZOOM_POSITION_LIMIT: cfg_model.zoom_position_limit = word[15:0];
      CFG_ZOOM_RATE_FLOOR:     cfg_model.zoom_rate_floor     = word[3:0];
      CFG_ZOOM_RATE_CEILING:   cfg_model.zoom_rate_ceiling   = word[3:0];
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mix of full-range, near-zero, near-limit and edge-of-range values.
  function automatic logic signed [15:0] random_field();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'(int'($urandom_range(0, 80)) - 40);
      2:       return 16'(int'($urandom_range(0, 4000)) - 2000);
      default: return $urandom_range(0, 1) ? 16'(16'h7FFF - $urandom_range(0, 2))
                                           : 16'(16'h8000 + $urandom_range(0, 2));
    endcase
  endfunction

  function automatic motion_cmd_t make_command(mode_e m, int pp, int tp,
                                               int ps, int ts, int zv);
    motion_cmd_t c;
    c.mode     = m;
    c.pan_pos  = 16'(pp);
    c.tilt_pos = 16'(tp);
    c.pan_spd  = 16'(ps);
    c.tilt_spd = 16'(ts);
    c.zoom_val = 16'(zv);
    return c;
  endfunction

  function automatic motion_cmd_t random_command();
    return make_command(mode_e'($urandom_range(0, 3)), random_field(), random_field(),
                        random_field(), random_field(), random_field());
  endfunction

  // Offer one command and hold it until the block takes it. Valid is left
  // high so a back-to-back command needs no second assignment in the step.
  task automatic send_command(motion_cmd_t c);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= c.mode;
    pan_position_i  <= c.pan_pos;
    tilt_position_i <= c.tilt_pos;
    pan_speed_i     <= c.pan_spd;
    tilt_speed_i    <= c.tilt_spd;
    zoom_value_i    <= c.zoom_val;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame(c);
    mode_count[c.mode]++;
  endtask

  task automatic send_random(int n);
    repeat (n) send_command(random_command());
  endtask

  // Drop valid and wait until every owed byte has left the block.
  task automatic wait_frames_done();
    in_valid_i <= 1'b0;
    while (frame_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all registers in index order; junk_upper fills the unused data
  // bits so the register masking gets exercised.
  task automatic load_settings(cfg_t s, bit junk_upper);
    cfg_idx_e    idx;
    logic [15:0] word;
    idx = idx.first();
    forever begin
      word = junk_upper ? 16'($urandom) : 16'h0000;
      case (idx)
        CFG_CAMERA_ADDRESS:      word[2:0]  = s.camera_address;
        CFG_PAN_POSITION_LIMIT:  word[14:0] = s.pan_position_limit;
        CFG_TILT_POSITION_LIMIT: word[14:0] = s.tilt_position_limit;
        CFG_PAN_RATE_LIMIT:      word[7:0]  = s.pan_rate_limit;
        CFG_TILT_RATE_LIMIT:     word[7:0]  = s.tilt_rate_limit;
        CFG_ZOOM_POSITION_LIMIT: word       = s.zoom_position_limit;
        CFG_ZOOM_RATE_FLOOR:     word[3:0]  = s.zoom_rate_floor;
        CFG_ZOOM_RATE_CEILING:   word[3:0]  = s.zoom_rate_ceiling;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= word;
      do @(posedge clk_i); while (!cfg_ready_o);
      store_register(idx, word);
      if (idx == idx.last()) break;
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Absolute pan/tilt at reset limits: zero, the field extremes, exactly at
  // and one past each limit, negative speed limits.
  task automatic test_aim_position();
    send_command(make_command(MODE_AIM_POS, 0, 0, 0, 0, random_field()));
    send_command(make_command(MODE_AIM_POS, 32767, -32768, 32767, -32768, random_field()));
    send_command(make_command(MODE_AIM_POS, -1, 1, -1, 25, random_field()));
    send_command(make_command(MODE_AIM_POS, 880, -300, 24, 20, random_field()));
    send_command(make_command(MODE_AIM_POS, -881, 301, 23, 21, random_field()));
  endtask

  // Velocity drive: stop, both directions, saturation just past the limit.
  task automatic test_aim_speed();
    send_command(make_command(MODE_AIM_SPD, random_field(), random_field(), 0, 0,
                              random_field()));
    send_command(make_command(MODE_AIM_SPD, random_field(), random_field(), 32767, -32768,
                              random_field()));
    send_command(make_command(MODE_AIM_SPD, random_field(), random_field(), -5, 7,
                              random_field()));
    send_command(make_command(MODE_AIM_SPD, random_field(), random_field(), 25, -21,
                              random_field()));
  endtask

  // Zoom target: negatives go to zero, large targets saturate.
  task automatic test_zoom_position();
    int targets[6] = '{-32768, -1, 0, 1023, 1024, 32767};
    foreach (targets[i])
      send_command(make_command(MODE_ZOOM_POS, random_field(), random_field(),
                                random_field(), random_field(), targets[i]));
  endtask

  // Zoom speed: dead band around zero, both floors, ceiling and extremes.
  task automatic test_zoom_speed();
    int speeds[9] = '{0, 1, -1, 2, -2, 7, 8, -32768, 32767};
    foreach (speeds[i])
      send_command(make_command(MODE_ZOOM_SPD, random_field(), random_field(),
                                random_field(), random_field(), speeds[i]));
  endtask

  // Walk the register file through all-ones, all-zeros, two random sets
  // and back to the defaults, changing the idling mix from each phase to the next.
  task automatic test_settings_sweep();
    cfg_t plan[5];
    plan[0] = '1;
    plan[1] = '0;
    plan[2] = cfg_t'({$urandom, $urandom, $urandom});
    plan[3] = cfg_t'({$urandom, $urandom, $urandom});
    plan[4] = CFG_RESET;
    foreach (plan[k]) begin
      wait_frames_done();
      load_settings(plan[k], k % 2 == 1);
      tx_idle_on = (k % 2 == 0);
      rx_idle_on = (k < 3);
      send_random(40);
    end
  endtask

  // Plain random traffic, reshuffling the idling mix every 25 commands.
  task automatic test_random_traffic();
    repeat (4) begin
      tx_idle_on = $urandom_range(0, 1);
      rx_idle_on = $urandom_range(0, 1);
      send_random(25);
    end
  endtask

  // Hold the output for a long stretch while the sender keeps offering
  // long frames, so the command queue fills and the input stalls.
  task automatic test_backpressure();
    wait_frames_done();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_left <= 300;
    repeat (12)
      send_command(make_command(MODE_AIM_POS, random_field(), random_field(),
                                random_field(), random_field(), random_field()));
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Output side: stall generator and frame checker
  // ---------------------------------------------------------------------

  // After each beat, draw how many cycles to stall before the next one.
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    int n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait     <= 0;
    end else if (rx_hold_left > 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait     <= rx_wait - 1;
    end else if (out_valid_o && !out_stall_i && rx_idle_on) begin
      n = $urandom_range(0, 14);
      out_stall_i <= (n > 0);
      rx_wait     <= (n > 0) ? n - 1 : 0;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each beat that moves against the oldest owed byte.
  always @(posedge clk_i) begin : frame_check
    frame_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_expect_q.size() == 0) begin
        $error("frame byte %02h with nothing owed", frame_byte_o);
        mismatch_count++;
      end else begin
        want = frame_expect_q.pop_front();
        bytes_checked++;
        if (frame_byte_o !== want.frame_byte) begin
          $error("frame_byte: expected %02h, actual %02h", want.frame_byte, frame_byte_o);
          mismatch_count++;
        end
        if (frame_last_o !== want.frame_last) begin
          $error("frame_last: expected %0b, actual %0b", want.frame_last, frame_last_o);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_aim_position();
    test_aim_speed();
    test_zoom_position();
    test_zoom_speed();
    test_settings_sweep();
    test_random_traffic();
    test_backpressure();

    // Let the last frame drain, then keep the clock running so that any stray
    // beat shows up.
    wait_frames_done();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d commands: %0d aim position, %0d aim speed, %0d zoom position, %0d zoom speed",
             mode_count[MODE_AIM_POS] + mode_count[MODE_AIM_SPD] +
             mode_count[MODE_ZOOM_POS] + mode_count[MODE_ZOOM_SPD],
             mode_count[MODE_AIM_POS], mode_count[MODE_AIM_SPD],
             mode_count[MODE_ZOOM_POS], mode_count[MODE_ZOOM_SPD]);
    $display("%0d frame bytes checked across %0d register loads, random idling and a long output hold",
             bytes_checked, settings_loaded);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Bound the run well past the slowest legal schedule.
  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
